// ===== rtl/core/vmt_pkg.sv =====
// vmt_pkg: shared types and constants of the vertex matrix transform.
// Used by vmt_div_lane, vertex_matrix_transform and vmt_checker.
`timescale 1ns / 1ps
package vmt_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int Q_W           = 32;   // component width, fixed by the fields
    localparam int N_REGS        = 8;
    localparam int CFG_IDX_W     = 4;    // one spare bit: writes past the last register are dropped
    localparam int CFG_W         = 64;

    localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        CMD_POINT   = 2'd0,
        CMD_NORMAL  = 2'd1,
        CMD_PROJECT = 2'd2,
        CMD_RSV     = 2'd3
    } t_cmd;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_LEFT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_RIGHT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_LEFT  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_RIGHT = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_LEFT  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_RIGHT = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_LEFT  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_RIGHT = 4'd7;

    // identity matrix, 1.0 in Q16.16
    function automatic logic [CFG_W-1:0] reg_reset(input int idx);
        logic [CFG_W-1:0] v;
        v = '0;
        case (idx)
            0, 5:    v = 64'h0000_0000_0001_0000;
            2, 7:    v = 64'h0001_0000_0000_0000;
            default: v = '0;
        endcase
        return v;
    endfunction

    // per-item control that rides alongside the divider
    typedef struct packed {
        logic proj;
        logic wz;
    } t_side;

    // per-component flags that ride alongside the divider
    typedef struct packed {
        logic neg;    // quotient sign
        logic ovf;    // quotient magnitude at least 2^32
        logic psat;   // clipped on the point/normal path
    } t_lane_flags;

endpackage

// ===== rtl/core/vmt_div_lane.sv =====
// vmt_div_lane: pipelined restoring divider, one quotient bit per stage.
// Depends on vmt_pkg. Carries the point/normal result alongside.
`timescale 1ns / 1ps
module vmt_div_lane #(
    parameter int ACC_W = 67
) (
    input  logic                       i_clk,
    input  logic [vmt_pkg::Q_W-1:0]    i_en,
    input  logic [ACC_W-1:0]           i_w,
    input  logic [ACC_W-1:0]           i_rem,
    input  logic [vmt_pkg::Q_W-1:0]    i_dlow,
    input  logic [vmt_pkg::Q_W-1:0]    i_pval,
    input  vmt_pkg::t_lane_flags       i_flags,
    output logic [vmt_pkg::Q_W-1:0]    o_q,
    output logic [vmt_pkg::Q_W-1:0]    o_pval,
    output vmt_pkg::t_lane_flags       o_flags
);
    localparam int DQ = vmt_pkg::Q_W;

    logic [ACC_W-1:0]          r_w    [DQ];
    logic [ACC_W-1:0]          r_rem  [DQ];
    logic [DQ-1:0]             r_dl   [DQ];
    logic [DQ-1:0]             r_q    [DQ];
    logic [DQ-1:0]             r_pv   [DQ];
    vmt_pkg::t_lane_flags      r_fl   [DQ];

    logic [ACC_W-1:0]          n_rem  [DQ];
    logic [DQ-1:0]             n_q    [DQ];
    logic [ACC_W-1:0]          s_w    [DQ];
    logic [ACC_W-1:0]          s_rem  [DQ];
    logic [DQ-1:0]             s_dl   [DQ];
    logic [DQ-1:0]             s_q    [DQ];
    logic [ACC_W:0]            s_trial[DQ];

    always_comb begin
        for (int j = 0; j < DQ; j++) begin
            if (j == 0) begin
                s_w[j]   = i_w;
                s_rem[j] = i_rem;
                s_dl[j]  = i_dlow;
                s_q[j]   = '0;
            end else begin
                s_w[j]   = r_w[j-1];
                s_rem[j] = r_rem[j-1];
                s_dl[j]  = r_dl[j-1];
                s_q[j]   = r_q[j-1];
            end
            s_trial[j] = {s_rem[j], s_dl[j][DQ-1]};
            if (s_trial[j] >= {1'b0, s_w[j]}) begin
                n_rem[j] = ACC_W'(s_trial[j] - {1'b0, s_w[j]});
                n_q[j]   = {s_q[j][DQ-2:0], 1'b1};
            end else begin
                n_rem[j] = s_trial[j][ACC_W-1:0];
                n_q[j]   = {s_q[j][DQ-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < DQ; j++) begin
            if (i_en[j]) begin
                r_w[j]   <= s_w[j];
                r_rem[j] <= n_rem[j];
                r_dl[j]  <= {s_dl[j][DQ-2:0], 1'b0};
                r_q[j]   <= n_q[j];
            end
        end
        if (i_en[0]) begin
            r_pv[0] <= i_pval;
            r_fl[0] <= i_flags;
        end
        for (int j = 1; j < DQ; j++) begin
            if (i_en[j]) begin
                r_pv[j] <= r_pv[j-1];
                r_fl[j] <= r_fl[j-1];
            end
        end
    end

    assign o_q     = r_q[DQ-1];
    assign o_pval  = r_pv[DQ-1];
    assign o_flags = r_fl[DQ-1];

endmodule

// ===== rtl/core/vertex_matrix_transform.sv =====
// Multiplies a vector by a 4x4 matrix held in configuration registers,
// accepting one vector per clock when no stall holds it; the stages are one of
// twelve 32x32 multipliers, one of row sums, one of scaling and divider set-up,
// 32 stages of a one-bit-per-stage divider that sets the depth, and the output
// register. Point and normal transforms run the same path as projection. A stall
// freezes only the stages that are full, so bubbles close up before the input
// is held. Command code 3 is taken and gives no result. The matrix may be
// written only while the pipeline is empty. Depends on vmt_pkg and vmt_div_lane.
`timescale 1ns / 1ps
module vertex_matrix_transform #(
    parameter int FRAC_BITS = vmt_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // item in
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_command,
    input  logic signed [vmt_pkg::Q_W-1:0]    i_vec_x,
    input  logic signed [vmt_pkg::Q_W-1:0]    i_vec_y,
    input  logic signed [vmt_pkg::Q_W-1:0]    i_vec_z,
    // result out
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [vmt_pkg::Q_W-1:0]    o_res_x,
    output logic signed [vmt_pkg::Q_W-1:0]    o_res_y,
    output logic signed [vmt_pkg::Q_W-1:0]    o_res_z,
    output logic                              o_zero_divisor,
    output logic                              o_saturated,
    // configuration
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [vmt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [vmt_pkg::CFG_W-1:0]         i_cfg_data
);
    localparam int QW    = vmt_pkg::Q_W;
    localparam int PW    = 2 * QW;
    localparam int ACC_W = ((PW + 2) > (QW + FRAC_BITS + 1) ? (PW + 2)
                                                            : (QW + FRAC_BITS + 1)) + 1;
    localparam int DD_W  = ACC_W + FRAC_BITS;
    localparam int HI_W  = DD_W - QW;
    localparam int DQ    = QW;
    localparam int OUT   = DQ + 3;
    localparam int NST   = DQ + 4;

    // ---------------- configuration ----------------
    logic [vmt_pkg::CFG_W-1:0] r_mtx [vmt_pkg::N_REGS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < vmt_pkg::N_REGS; k++) begin
                r_mtx[k] <= vmt_pkg::reg_reset(k);
            end
        end else if (i_cfg_valid && i_cfg_index <= vmt_pkg::REG_ROW3_RIGHT) begin
            r_mtx[i_cfg_index[2:0]] <= i_cfg_data;
        end
    end

    // ---------------- flow control ----------------
    logic [NST-1:0] r_v;
    logic [NST-1:0] en;

    always_comb begin
        en[NST-1] = !r_v[NST-1] || !i_stall;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid && (vmt_pkg::t_cmd'(i_command) != vmt_pkg::CMD_RSV);
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ---------------- stage 0: products ----------------
    logic signed [QW-1:0]  s_vec  [3];
    logic signed [QW-1:0]  s_ent  [4][4];
    logic signed [PW-1:0]  r_prod [4][3];
    logic signed [QW-1:0]  r_tr   [4];
    vmt_pkg::t_cmd         r_cmd0, r_cmd1;

    always_comb begin
        s_vec[0] = i_vec_x;
        s_vec[1] = i_vec_y;
        s_vec[2] = i_vec_z;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                s_ent[r][c] = (c % 2 == 1) ? r_mtx[r*2 + c/2][PW-1:QW]
                                           : r_mtx[r*2 + c/2][QW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r][c] <= s_ent[r][c] * s_vec[c];
                end
                r_tr[r] <= s_ent[r][3];
            end
            r_cmd0 <= vmt_pkg::t_cmd'(i_command);
        end
    end

    // ---------------- stage 1: row sums at 2*FRAC_BITS ----------------
    logic signed [ACC_W-1:0] r_sum [4];
    logic signed [ACC_W-1:0] s_tr  [4];

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            s_tr[r] = (r_cmd0 != vmt_pkg::CMD_NORMAL) ? (ACC_W'(r_tr[r]) <<< FRAC_BITS) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            for (int r = 0; r < 4; r++) begin
                r_sum[r] <= ACC_W'(r_prod[r][0]) + ACC_W'(r_prod[r][1])
                          + ACC_W'(r_prod[r][2]) + s_tr[r];
            end
            r_cmd1 <= r_cmd0;
        end
    end

    // ---------------- stage 2: rescale / divider set-up ----------------
    logic [ACC_W-1:0]        s_wmag;
    logic                    s_wneg;
    logic [ACC_W-1:0]        s_nmag [3];
    logic [DD_W-1:0]         s_dd   [3];
    logic [HI_W-1:0]         s_hi   [3];
    logic signed [ACC_W-1:0] s_sh   [3];
    logic                    s_fit  [3];

    logic [ACC_W-1:0]        r_w2;
    logic [ACC_W-1:0]        r_rem2  [3];
    logic [QW-1:0]           r_dl2   [3];
    logic [QW-1:0]           r_pv2   [3];
    vmt_pkg::t_lane_flags    r_fl2   [3];
    vmt_pkg::t_side          r_side2;

    always_comb begin
        s_wneg = r_sum[3][ACC_W-1];
        s_wmag = s_wneg ? ACC_W'(-r_sum[3]) : ACC_W'(r_sum[3]);
        for (int r = 0; r < 3; r++) begin
            s_nmag[r] = r_sum[r][ACC_W-1] ? ACC_W'(-r_sum[r]) : ACC_W'(r_sum[r]);
            s_dd[r]   = {s_nmag[r], {FRAC_BITS{1'b0}}};
            s_hi[r]   = s_dd[r][DD_W-1:QW];
            s_sh[r]   = r_sum[r] >>> FRAC_BITS;
            s_fit[r]  = (&s_sh[r][ACC_W-1:QW-1]) || !(|s_sh[r][ACC_W-1:QW-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_w2 <= s_wmag;
            for (int r = 0; r < 3; r++) begin
                r_rem2[r]     <= ACC_W'(s_hi[r]);
                r_dl2[r]      <= s_dd[r][QW-1:0];
                r_fl2[r].neg  <= r_sum[r][ACC_W-1] ^ s_wneg;
                r_fl2[r].ovf  <= ACC_W'(s_hi[r]) >= s_wmag;
                r_fl2[r].psat <= !s_fit[r];
                if (s_fit[r]) begin
                    r_pv2[r] <= s_sh[r][QW-1:0];
                end else begin
                    r_pv2[r] <= s_sh[r][ACC_W-1] ? vmt_pkg::Q_MIN : vmt_pkg::Q_MAX;
                end
            end
            r_side2.proj <= (r_cmd1 == vmt_pkg::CMD_PROJECT);
            r_side2.wz   <= (r_sum[3] == '0);
        end
    end

    // ---------------- stages 3 .. 3+DQ-1: dividers ----------------
    vmt_pkg::t_side          r_side [DQ];
    logic [QW-1:0]           d_q    [3];
    logic [QW-1:0]           d_pv   [3];
    vmt_pkg::t_lane_flags    d_fl   [3];

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_side[0] <= r_side2;
        end
        for (int j = 1; j < DQ; j++) begin
            if (en[3+j]) begin
                r_side[j] <= r_side[j-1];
            end
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        vmt_div_lane #(
            .ACC_W (ACC_W)
        ) u_lane (
            .i_clk   (i_clk),
            .i_en    (en[3 +: DQ]),
            .i_w     (r_w2),
            .i_rem   (r_rem2[g]),
            .i_dlow  (r_dl2[g]),
            .i_pval  (r_pv2[g]),
            .i_flags (r_fl2[g]),
            .o_q     (d_q[g]),
            .o_pval  (d_pv[g]),
            .o_flags (d_fl[g])
        );
    end

    // ---------------- output stage ----------------
    logic [QW-1:0] s_res [3];
    logic [2:0]    s_sat;
    logic [QW-1:0] r_res [3];
    logic          r_zdiv, r_sat;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            s_res[r] = d_pv[r];
            s_sat[r] = d_fl[r].psat;
            if (r_side[DQ-1].proj) begin
                if (r_side[DQ-1].wz) begin
                    s_res[r] = '0;
                    s_sat[r] = 1'b0;
                end else if (d_fl[r].ovf) begin
                    s_res[r] = d_fl[r].neg ? vmt_pkg::Q_MIN : vmt_pkg::Q_MAX;
                    s_sat[r] = 1'b1;
                end else if (d_fl[r].neg) begin
                    s_sat[r] = d_q[r] > vmt_pkg::Q_MIN;
                    s_res[r] = s_sat[r] ? vmt_pkg::Q_MIN : QW'(-d_q[r]);
                end else begin
                    s_sat[r] = d_q[r][QW-1];
                    s_res[r] = s_sat[r] ? vmt_pkg::Q_MAX : d_q[r];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[OUT]) begin
            for (int r = 0; r < 3; r++) begin
                r_res[r] <= s_res[r];
            end
            r_zdiv <= r_side[DQ-1].proj && r_side[DQ-1].wz;
            r_sat  <= |s_sat;
        end
    end

    assign o_valid        = r_v[OUT];
    assign o_res_x        = r_res[0];
    assign o_res_y        = r_res[1];
    assign o_res_z        = r_res[2];
    assign o_zero_divisor = r_zdiv;
    assign o_saturated    = r_sat;

endmodule

// ===== rtl/core/vmt_checker.sv =====
// vmt_checker: port-level checks on vertex_matrix_transform, bound to the top.
// Depends on vmt_pkg.
`timescale 1ns / 1ps
module vmt_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_stall,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic signed [vmt_pkg::Q_W-1:0] o_res_x,
    input logic signed [vmt_pkg::Q_W-1:0] o_res_y,
    input logic signed [vmt_pkg::Q_W-1:0] o_res_z,
    input logic                           o_zero_divisor,
    input logic                           o_saturated
);

    // a zero divisor beat carries zeros and no clip flag
    a_zdiv_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_divisor |->
            !o_saturated && o_res_x == '0 && o_res_y == '0 && o_res_z == '0)
        else $error("zero divisor beat not clean");

    // input is only held back when a result is waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat straight after reset");

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_res_x) && $stable(o_res_y)
            && $stable(o_res_z) && $stable(o_saturated))
        else $error("stalled result beat changed");

endmodule

bind vertex_matrix_transform vmt_checker u_vmt_checker (.*);
